@@ sv/script_source_tokenizer_macros.svh @@
// ---------------------------------------------------------------------------
// script_source_tokenizer_macros.svh
// Assertion macros for the script source tokenizer. They expand to nothing
// when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_MACROS_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define SST_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SST_ASSERT_ALWAYS(lbl, cond, msg)
`define SST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/sst_pkg.sv @@
// ---------------------------------------------------------------------------
// sst_pkg
// Types, token codes and keyword tables shared by the tokenizer modules.
// ---------------------------------------------------------------------------
package sst_pkg;

	localparam int MAX_KEYWORD_LEN = 11;
	localparam int NUM_KW = 20;
	localparam int POS_W = 25;
	localparam logic [POS_W-1:0] MAX_SOURCE_BYTES = 25'd16777216;
	localparam logic [POS_W-1:0] MAX_START = 25'd16777215;
	localparam int QDEPTH = 4;

	localparam logic [5:0] T_END = 6'd0;
	localparam logic [5:0] T_UNKNOWN = 6'd1;
	localparam logic [5:0] T_NUMBER = 6'd2;
	localparam logic [5:0] T_SYMBOL = 6'd3;
	localparam logic [5:0] T_STRING = 6'd4;
	localparam logic [5:0] T_PERIOD = 6'd16;
	localparam logic [5:0] T_SEMICOLON = 6'd20;
	localparam logic [5:0] T_KW0 = 6'd33;

	typedef struct packed {
		logic        kind;
		logic [5:0]  token_type;
		logic [23:0] span_start;
		logic [24:0] span_length;
		logic [15:0] line_number;
		logic [15:0] token_ordinal;
		logic        newline_before;
		logic [7:0]  string_char;
		logic        unterminated;
	} sst_res_t;

	localparam logic [87:0] KW_TXT [NUM_KW] = '{
		88'("if"), 88'("fn"), 88'("else"), 88'("for"), 88'("while"),
		88'("print"), 88'("ret"), 88'("and"), 88'("or"), 88'("class"),
		88'("method"), 88'("field"), 88'("constructor"), 88'("inherits"),
		88'("new"), 88'("this"), 88'("super"), 88'("true"), 88'("false"),
		88'("null")};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd2, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd3, 4'd3, 4'd2, 4'd5,
		4'd6, 4'd5, 4'd11, 4'd8, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd4};

	function automatic logic [19:0] ident_feed(input logic [19:0] cand,
		input logic [3:0] il, input logic [7:0] c);
		logic [19:0] r;
		logic [3:0] pos;
		r = cand;
		if (il >= 4'(MAX_KEYWORD_LEN)) begin
			r = '0;
		end else begin
			for (int k = 0; k < NUM_KW; k++) begin
				pos = KW_LEN[k] - il - 4'd1;
				if (il >= KW_LEN[k] || KW_TXT[k][pos*8 +: 8] != c)
					r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic [5:0] ident_type(input logic [19:0] cand,
		input logic [3:0] il);
		logic [5:0] t;
		t = T_SYMBOL;
		for (int k = NUM_KW - 1; k >= 0; k--)
			if (cand[k] && KW_LEN[k] == il) t = T_KW0 + 6'(k);
		return t;
	endfunction

	function automatic logic [5:0] single_op(input logic [7:0] c);
		case (c)
			"*": return 6'd5;
			"%": return 6'd6;
			"/": return 6'd7;
			"^": return 6'd8;
			")": return 6'd9;
			"(": return 6'd10;
			"]": return 6'd11;
			"[": return 6'd12;
			"}": return 6'd13;
			"{": return 6'd14;
			",": return 6'd15;
			".": return 6'd16;
			":": return 6'd17;
			"#": return 6'd18;
			"&": return 6'd19;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] pair_op(input logic [7:0] c);
		case (c)
			"=": return 6'd21;
			"+": return 6'd23;
			"-": return 6'd25;
			"!": return 6'd27;
			">": return 6'd29;
			"<": return 6'd31;
			default: return 6'd0;
		endcase
	endfunction

endpackage

@@ sv/script_source_tokenizer.sv @@
// ---------------------------------------------------------------------------
// script_source_tokenizer
// Streaming lexer: one source byte per transaction in, token and decoded
// string character results out.
// ---------------------------------------------------------------------------
// Channel  | Handshake           | Payload
// input    | in_valid / in_ready | src_byte, end_of_source
// output   | out_valid/out_ready | kind, token_type, span_start, span_length,
//          |                     | line_number, token_ordinal, newline_before,
//          |                     | string_char, unterminated
//
// Each input transaction is scanned in the cycle it is accepted; its zero to
// three results enter a four-entry result queue behind any queued results
// and leave it one per cycle while out_ready is high. A byte is taken every
// cycle while the queue holds at most one result, so a stream giving at most
// one result per byte runs at one byte per cycle while out_ready stays high.
// Reset returns the scanner to idle at source offset 0 and empties the queue.
// With the output stalled, in_ready falls once the queue holds two results.
// ---------------------------------------------------------------------------
`include "script_source_tokenizer_macros.svh"

module script_source_tokenizer import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [5:0]  token_type,
	output logic [23:0] span_start,
	output logic [24:0] span_length,
	output logic [15:0] line_number,
	output logic [15:0] token_ordinal,
	output logic        newline_before,
	output logic [7:0]  string_char,
	output logic        unterminated
);

	// Scanner modes.
	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_NUM_INT  = 4'd1;
	localparam logic [3:0] M_NUM_DOT  = 4'd2;
	localparam logic [3:0] M_NUM_FRAC = 4'd3;
	localparam logic [3:0] M_IDENT    = 4'd4;
	localparam logic [3:0] M_SEMI     = 4'd5;
	localparam logic [3:0] M_OP2      = 4'd6;
	localparam logic [3:0] M_STR      = 4'd7;
	localparam logic [3:0] M_ESC      = 4'd8;

	logic [3:0]       mode_q;
	logic [7:0]       pend_q;
	logic [19:0]      cand_q;
	logic [3:0]       ilen_q;
	logic [POS_W-1:0] tbeg_q;
	logic [POS_W-1:0] bpos_q;
	logic [15:0]      line_q;
	logic [15:0]      ord_q;
	logic             snl_q;

	logic [3:0]       m_d;
	logic [7:0]       pend_d;
	logic [19:0]      cand_d;
	logic [3:0]       ilen_d;
	logic [POS_W-1:0] tbeg_d;
	logic [POS_W-1:0] bpos_d;
	logic [15:0]      line_d;
	logic [15:0]      ord_d;
	logic             snl_d;
	logic [1:0]       res_n;
	sst_res_t [2:0]   res;

	logic             in_acc;
	logic             out_acc;
	sst_res_t         head;
	logic [2:0]       qcount;

	// Build one result; the start offset saturates below the source limit.
	function automatic sst_res_t mk(input logic k, input logic [5:0] t,
		input logic [POS_W-1:0] st, input logic [POS_W-1:0] ln,
		input logic [15:0] li, input logic [15:0] od, input logic nl,
		input logic [7:0] ch, input logic un);
		sst_res_t r;
		r.kind = k;
		r.token_type = t;
		r.span_start = (st > MAX_START) ? MAX_START[23:0] : st[23:0];
		r.span_length = ln;
		r.line_number = li;
		r.token_ordinal = od;
		r.newline_before = nl;
		r.string_char = ch;
		r.unterminated = un;
		return r;
	endfunction

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Single-pass scan of the byte against the current scanner state. The
	// blocking variables follow the order in which the state changes, so a
	// token emitted after an ordinal bump sees the bumped count.
	always_comb begin
		logic             eos;
		logic             done;
		logic             dig;
		logic             alp;
		logic             match;
		logic [5:0]       t;
		logic [POS_W-1:0] len0;
		logic [POS_W-1:0] dot;
		logic [POS_W-1:0] s;
		logic [7:0]       c;
		c = src_byte;
		eos = end_of_source || (c == 8'd0);
		dig = (c >= "0") && (c <= "9");
		alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		done = 1'b0;
		m_d = mode_q;
		pend_d = pend_q;
		cand_d = cand_q;
		ilen_d = ilen_q;
		tbeg_d = tbeg_q;
		bpos_d = bpos_q;
		line_d = line_q;
		ord_d = ord_q;
		snl_d = snl_q;
		res_n = '0;
		res = '0;
		len0 = bpos_q - tbeg_q;
		t = '0;
		match = 1'b0;
		dot = '0;
		s = '0;

		case (mode_q)
			M_NUM_INT, M_NUM_FRAC: begin
				if (!eos && dig) begin
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else if (!eos && c == "." && mode_q == M_NUM_INT) begin
					m_d = M_NUM_DOT;
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else begin
					res[res_n] = mk(1'b0, T_NUMBER, tbeg_d, len0, line_d, ord_d, snl_d,
						8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end
			end
			M_NUM_DOT: begin
				if (!eos && dig) begin
					m_d = M_NUM_FRAC;
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else begin
					dot = (bpos_d > tbeg_d) ? bpos_d - 1'b1 : tbeg_d;
					res[res_n] = mk(1'b0, T_NUMBER, tbeg_d, dot - tbeg_d, line_d, ord_d,
						snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
					if (ord_d != 16'hFFFF) ord_d = ord_d + 1'b1;
					res[res_n] = mk(1'b0, T_PERIOD, dot, bpos_d - dot, line_d, ord_d,
						snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
				end
			end
			M_IDENT: begin
				if (!eos && (alp || dig)) begin
					cand_d = ident_feed(cand_d, ilen_d, c);
					if (ilen_d != 4'd15) ilen_d = ilen_d + 1'b1;
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else begin
					res[res_n] = mk(1'b0, ident_type(cand_d, ilen_d), tbeg_d, len0,
						line_d, ord_d, snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end
			end
			M_SEMI: begin
				if (!eos && c == ";") begin
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else begin
					res[res_n] = mk(1'b0, T_SEMICOLON, tbeg_d, len0, line_d, ord_d,
						snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end
			end
			M_OP2: begin
				t = pair_op(pend_q);
				// "++" and "--" repeat the byte; the others pair with "=".
				match = (pend_q == "+" || pend_q == "-") ? (c == pend_q) : (c == "=");
				if (!eos && match) begin
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					res[res_n] = mk(1'b0, t + 6'd1, tbeg_d, bpos_d - tbeg_d, line_d,
						ord_d, snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
					m_d = M_IDLE;
					done = 1'b1;
				end else begin
					res[res_n] = mk(1'b0, t, tbeg_d, len0, line_d, ord_d, snl_d,
						8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end
			end
			M_STR: begin
				if (eos) begin
					res[res_n] = mk(1'b0, T_STRING, tbeg_d, len0, line_d, ord_d, snl_d,
						8'd0, 1'b1);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end else if (c == "\"") begin
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					res[res_n] = mk(1'b0, T_STRING, tbeg_d, bpos_d - tbeg_d, line_d,
						ord_d, snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
					m_d = M_IDLE;
					done = 1'b1;
				end else if (c == "\\") begin
					m_d = M_ESC;
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end else begin
					res[res_n] = mk(1'b1, T_STRING, bpos_d, 25'd1, line_d, ord_d, 1'b0,
						c, 1'b0);
					res_n = res_n + 2'd1;
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					done = 1'b1;
				end
			end
			M_ESC: begin
				if (eos) begin
					res[res_n] = mk(1'b0, T_STRING, tbeg_d, len0, line_d, ord_d, snl_d,
						8'd0, 1'b1);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end else begin
					s = (bpos_d != '0) ? bpos_d - 1'b1 : '0;
					// Only the n and t escapes produce a character.
					if (c == "n") begin
						res[res_n] = mk(1'b1, T_STRING, s, 25'd2, line_d, ord_d, 1'b0,
							8'd10, 1'b0);
						res_n = res_n + 2'd1;
					end else if (c == "t") begin
						res[res_n] = mk(1'b1, T_STRING, s, 25'd2, line_d, ord_d, 1'b0,
							8'd9, 1'b0);
						res_n = res_n + 2'd1;
					end
					if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
					m_d = M_STR;
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (!done) begin
			m_d = M_IDLE;
			if (eos) begin
				// END closes the source; the scanner starts over at offset 0.
				if (ord_d != 16'hFFFF) ord_d = ord_d + 1'b1;
				res[res_n] = mk(1'b0, T_END, bpos_d, 25'd0, line_d, ord_d, snl_d,
					8'd0, 1'b0);
				res_n = res_n + 2'd1;
				pend_d = '0;
				cand_d = '1;
				ilen_d = '0;
				tbeg_d = '0;
				bpos_d = '0;
				line_d = '0;
				ord_d = '0;
				snl_d = 1'b0;
			end else if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
				if (c == "\n") begin
					snl_d = 1'b1;
					if (line_d != 16'hFFFF) line_d = line_d + 1'b1;
					ord_d = '0;
				end
				if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
			end else begin
				tbeg_d = bpos_d;
				if (ord_d != 16'hFFFF) ord_d = ord_d + 1'b1;
				if (bpos_d < MAX_SOURCE_BYTES) bpos_d = bpos_d + 1'b1;
				if (dig) begin
					m_d = M_NUM_INT;
				end else if (alp) begin
					cand_d = ident_feed(20'hFFFFF, 4'd0, c);
					ilen_d = 4'd1;
					m_d = M_IDENT;
				end else if (c == "\"") begin
					m_d = M_STR;
				end else if (c == ";") begin
					m_d = M_SEMI;
				end else if (pair_op(c) != 6'd0) begin
					pend_d = c;
					m_d = M_OP2;
				end else begin
					t = single_op(c);
					res[res_n] = mk(1'b0, (t != 6'd0) ? t : T_UNKNOWN, tbeg_d, 25'd1,
						line_d, ord_d, snl_d, 8'd0, 1'b0);
					res_n = res_n + 2'd1;
					snl_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			cand_q <= '1;
			ilen_q <= '0;
			tbeg_q <= '0;
			bpos_q <= '0;
			line_q <= '0;
			ord_q <= '0;
			snl_q <= 1'b0;
		end else if (in_acc) begin
			mode_q <= m_d;
			pend_q <= pend_d;
			cand_q <= cand_d;
			ilen_q <= ilen_d;
			tbeg_q <= tbeg_d;
			bpos_q <= bpos_d;
			line_q <= line_d;
			ord_q <= ord_d;
			snl_q <= snl_d;
		end
	end

	sst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (in_acc ? res_n : 2'd0),
		.push_rec (res),
		.pop      (out_acc),
		.head     (head),
		.count    (qcount)
	);

	// Room for the worst case of three results from the next byte.
	assign in_ready = (qcount <= 3'd1);
	assign out_valid = (qcount != 3'd0);

	assign kind = head.kind;
	assign token_type = head.token_type;
	assign span_start = head.span_start;
	assign span_length = head.span_length;
	assign line_number = head.line_number;
	assign token_ordinal = head.token_ordinal;
	assign newline_before = head.newline_before;
	assign string_char = head.string_char;
	assign unterminated = head.unterminated;

	`SST_ASSERT_ALWAYS(a_queue_bound, qcount <= 3'(QDEPTH), "result queue overflow")
	`SST_ASSERT_NEXT(a_no_result_hold, in_acc && res_n == 2'd0 && !out_acc, qcount == $past(qcount), "queue count moved without traffic")
	`SST_ASSERT_ALWAYS(a_pos_bound, bpos_q <= MAX_SOURCE_BYTES && tbeg_q <= bpos_q, "source position out of range")
	`SST_ASSERT_NEXT(a_end_restart, in_acc && (end_of_source || src_byte == 8'd0), bpos_q == '0 && mode_q == M_IDLE, "end of source did not restart scanner")

endmodule

@@ sv/sst_queue.sv @@
// ---------------------------------------------------------------------------
// sst_queue
// Result queue: takes up to three results per cycle, hands out one.
// ---------------------------------------------------------------------------
module sst_queue import sst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  sst_res_t [2:0]     push_rec,
	input  logic               pop,
	output sst_res_t           head,
	output logic [2:0]         count
);

	sst_res_t   mem_q [QDEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < push_n) mem_q[wr_q + 2'(i)] <= push_rec[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push_n;
			rd_q <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	assign head = mem_q[rd_q];
	assign count = cnt_q;

endmodule

@@ sim/tb_script_source_tokenizer.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_script_source_tokenizer
// Self-checking bench for the streaming source tokenizer. Directed source
// fragments cover every operator, keyword, number form and string escape,
// then random source text is fed under several idle and stall patterns.
// A lexer model in the bench predicts every token and string character.
// ---------------------------------------------------------------------------
module tb_script_source_tokenizer;
	import sst_pkg::*;

	// Scanner modes of the bench's lexer model.
	typedef enum int {
		SM_IDLE, SM_NUM_INT, SM_NUM_DOT, SM_NUM_FRAC, SM_IDENT,
		SM_SEMI, SM_OP2, SM_STR, SM_ESC
	} scan_mode_e;

	localparam int KIND_TOKEN = 0;
	localparam int KIND_CHAR = 1;
	localparam int SRC_LIMIT = 16777216;

	// Lexer model together with the queue of predicted results.
	class token_scoreboard;
		sst_res_t pending_q[$];
		int mismatches;
		scan_mode_e mode;
		bit [7:0] op_char;
		bit [19:0] kw_cand;
		int id_len, tok_begin, pos, line_cnt, line_toks;
		bit nl_seen;
		string kw_words[20];

		function new();
			kw_words = '{"if", "fn", "else", "for", "while", "print", "ret", "and",
				"or", "class", "method", "field", "constructor", "inherits", "new",
				"this", "super", "true", "false", "null"};
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			mode = SM_IDLE; op_char = 0; kw_cand = '1; id_len = 0;
			tok_begin = 0; pos = 0; line_cnt = 0; line_toks = 0; nl_seen = 0;
		endfunction

		function void step_pos();
			if (pos < SRC_LIMIT) pos++;
		endfunction

		function void bump();
			if (line_toks < 65535) line_toks++;
		endfunction

		function void emit(bit k, int tt, int st, int ln, bit nl, int ch, bit unt);
			sst_res_t r;
			if (st > SRC_LIMIT - 1) st = SRC_LIMIT - 1;
			r.kind = k; r.token_type = tt[5:0]; r.span_start = st[23:0];
			r.span_length = ln[24:0]; r.line_number = line_cnt[15:0];
			r.token_ordinal = line_toks[15:0]; r.newline_before = nl;
			r.string_char = ch[7:0]; r.unterminated = unt;
			pending_q = {pending_q, r};
		endfunction

		function void emit_token(int tt, int st, int ln, bit unt);
			emit(KIND_TOKEN, tt, st, ln, nl_seen, 0, unt);
			nl_seen = 0;
		endfunction

		function void feed_ident(bit [7:0] c);
			string w;
			if (id_len >= MAX_KEYWORD_LEN) kw_cand = '0;
			else
				for (int k = 0; k < 20; k++) begin
					w = kw_words[k];
					if (id_len >= w.len() || w[id_len] != c) kw_cand[k] = 0;
				end
			if (id_len < 15) id_len++;
		endfunction

		function int ident_kind();
			for (int k = 0; k < 20; k++)
				if (kw_cand[k] && kw_words[k].len() == id_len) return T_KW0 + k;
			return T_SYMBOL;
		endfunction

		function int op_single(bit [7:0] c);
			case (c)
				"*": return 5; "%": return 6; "/": return 7; "^": return 8;
				")": return 9; "(": return 10; "]": return 11; "[": return 12;
				"}": return 13; "{": return 14; ",": return 15; ".": return 16;
				":": return 17; "#": return 18; "&": return 19;
				default: return 0;
			endcase
		endfunction

		function int op_pair(bit [7:0] c);
			case (c)
				"=": return 21; "+": return 23; "-": return 25;
				"!": return 27; ">": return 29; "<": return 31;
				default: return 0;
			endcase
		endfunction

		// Predicts the results of one accepted input transaction.
		function void note_input(bit [7:0] c, bit eos);
			bit fin, dig, alp;
			int span, dot, t, s;
			fin = eos || c == 0;
			dig = c >= "0" && c <= "9";
			alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
			span = pos - tok_begin;
			case (mode)
				SM_NUM_INT, SM_NUM_FRAC: begin
					if (!fin && dig) begin step_pos(); return; end
					if (!fin && c == "." && mode == SM_NUM_INT) begin
						mode = SM_NUM_DOT; step_pos(); return;
					end
					emit_token(T_NUMBER, tok_begin, span, 0);
				end
				SM_NUM_DOT: begin
					if (!fin && dig) begin mode = SM_NUM_FRAC; step_pos(); return; end
					dot = pos > tok_begin ? pos - 1 : tok_begin;
					emit_token(T_NUMBER, tok_begin, dot - tok_begin, 0);
					bump();
					emit_token(T_PERIOD, dot, pos - dot, 0);
				end
				SM_IDENT: begin
					if (!fin && (alp || dig)) begin feed_ident(c); step_pos(); return; end
					emit_token(ident_kind(), tok_begin, span, 0);
				end
				SM_SEMI: begin
					if (!fin && c == ";") begin step_pos(); return; end
					emit_token(T_SEMICOLON, tok_begin, span, 0);
				end
				SM_OP2: begin
					t = op_pair(op_char);
					if (!fin && c == ((op_char == "+" || op_char == "-") ? op_char : "=")) begin
						step_pos();
						emit_token(t + 1, tok_begin, pos - tok_begin, 0);
						mode = SM_IDLE;
						return;
					end
					emit_token(t, tok_begin, span, 0);
				end
				SM_STR: begin
					if (fin) emit_token(T_STRING, tok_begin, span, 1);
					else if (c == "\"") begin
						step_pos();
						emit_token(T_STRING, tok_begin, pos - tok_begin, 0);
						mode = SM_IDLE;
						return;
					end else if (c == "\\") begin
						mode = SM_ESC; step_pos(); return;
					end else begin
						emit(KIND_CHAR, T_STRING, pos, 1, 0, c, 0);
						step_pos();
						return;
					end
				end
				SM_ESC: begin
					if (fin) emit_token(T_STRING, tok_begin, span, 1);
					else begin
						s = pos > 0 ? pos - 1 : 0;
						if (c == "n") emit(KIND_CHAR, T_STRING, s, 2, 0, 10, 0);
						else if (c == "t") emit(KIND_CHAR, T_STRING, s, 2, 0, 9, 0);
						step_pos();
						mode = SM_STR;
						return;
					end
				end
				default: ;
			endcase
			mode = SM_IDLE;
			if (fin) begin
				bump();
				emit_token(T_END, pos, 0, 0);
				clear();
				return;
			end
			if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
				if (c == "\n") begin
					nl_seen = 1;
					if (line_cnt < 65535) line_cnt++;
					line_toks = 0;
				end
				step_pos();
				return;
			end
			tok_begin = pos;
			bump();
			step_pos();
			if (dig) mode = SM_NUM_INT;
			else if (alp) begin
				kw_cand = '1; id_len = 0; feed_ident(c); mode = SM_IDENT;
			end else if (c == "\"") mode = SM_STR;
			else if (c == ";") mode = SM_SEMI;
			else if (op_pair(c) != 0) begin op_char = c; mode = SM_OP2; end
			else begin
				t = op_single(c);
				emit_token(t != 0 ? t : T_UNKNOWN, tok_begin, 1, 0);
			end
		endfunction

		// Compares one accepted result against the oldest prediction.
		function void check_result(sst_res_t got);
			sst_res_t exp_r;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			exp_r = pending_q.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result differs: expected %p, got %p", exp_r, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, end_of_source, out_valid, out_ready;
	logic [7:0] src_byte;
	sst_res_t got_res;

	script_source_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.src_byte(src_byte), .end_of_source(end_of_source),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(got_res.kind), .token_type(got_res.token_type),
		.span_start(got_res.span_start), .span_length(got_res.span_length),
		.line_number(got_res.line_number), .token_ordinal(got_res.token_ordinal),
		.newline_before(got_res.newline_before), .string_char(got_res.string_char),
		.unterminated(got_res.unterminated)
	);

	token_scoreboard sb;
	// Idle percentages of the two sides; the sink hold-off forces a long stall.
	int send_idle_pct, recv_stall_pct;
	bit sink_hold;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sends one byte transaction; valid stays high until accepted and is
	// dropped only when the sender idles.
	task automatic send_byte(input bit [7:0] b, input bit eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; src_byte <= b; end_of_source <= eos;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b, eos);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
	endtask

	// Picks a random fragment of plausible source text; some is noise.
	function automatic string random_fragment();
		string words[12];
		string frag;
		words = '{"while", "constructor", "inherits", "null", "fn", "x_1", "abcdefghijklmnop",
			"12.5", "7.", "==", "++", ";;;"};
		case ($urandom_range(9))
			0, 1, 2: frag = words[$urandom_range(11)];
			3: frag = $sformatf("%0d", $urandom);
			4: frag = "\"ab\\n\\t\\q c\"";
			5: frag = "\n";
			6: frag = " ";
			7: frag = "+-!<>=*%/^()[]{},.:#&";
			default: begin
				frag = " ";
				frag[0] = $urandom_range(255);
			end
		endcase
		return frag;
	endfunction

	// Receiver: stalls at random and during the hold-off, checks each result.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			out_ready <= !sink_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(got_res);

	initial begin
		#20000000;
		$display("script_source_tokenizer: mismatch");
		$finish;
	end

	initial begin
		int sent;
		string frag;
		sb = new();
		in_valid = 0; src_byte = 0; end_of_source = 0;
		send_idle_pct = 0; recv_stall_pct = 0; sink_hold = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part: all operators, keywords, numbers, strings, escapes.
		send_text("if fn else for while print ret and or class\n");
		send_text("method field constructor inherits new this super true false null");
		send_text(" 12.5 7. 3.x;;; == = += ++ -- - != ! >= > <= <");
		send_text("*%/^)([]{},.:#&@\t\r\"q\\n\\t\\z\"");
		send_byte(8'hff, 0);
		send_byte(8'h80, 0);
		send_text("\"open");
		send_byte(8'h00, 0);
		send_text("abcdefghijklmnopqrs _Z9");
		send_byte(8'h5a, 1);
		send_text("\"x\\");
		send_byte(8'h00, 1);

		// Random source text under several idle patterns.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 10) : 0;
			recv_stall_pct = (ph == 2) ? 52 : (ph == 3 ? 10 : 0);
			if (ph == 2) fork
				begin
					sink_hold = 1;
					repeat (60) @(negedge clk);
					sink_hold = 0;
				end
			join_none
			sent = 0;
			while (sent < 65) begin
				frag = random_fragment();
				send_text(frag);
				sent += frag.len();
				if ($urandom_range(15) == 0) send_text(" ");
			end
			send_byte($urandom_range(255), 1);
		end
		in_valid <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("script_source_tokenizer: match");
		else
			$display("script_source_tokenizer: mismatch");
		$finish;
	end

endmodule
